FILE: design/bca_pkg.sv
// shared widths and operation codes of the bitmap chunk allocator
`default_nettype none
package bca_pkg;

    localparam int ADDR_W = 32;
    localparam int CS_W   = 17;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [APB_AW-1:0] REG_BASE_ADDRESS = 3'd0;
    localparam logic [APB_AW-1:0] REG_CHUNK_SIZE   = 3'd4;

    localparam logic [CS_W-1:0] CHUNK_SIZE_RESET = 17'd64;

endpackage
`default_nettype wire

FILE: design/bca_if.sv
// request and response channel interfaces of the bitmap chunk allocator
`default_nettype none
interface bca_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [bca_pkg::ADDR_W-1:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

interface bca_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bca_pkg::ADDR_W-1:0] chunk_address;
    logic                       ok;

    modport source (output valid, output chunk_address, output ok, input ready);
    modport sink (input valid, input chunk_address, input ok, output ready);
endinterface
`default_nettype wire

FILE: design/bitmap_chunk_allocator.sv
// bitmap chunk allocator top level: slab bitmap memory, scan and divide sequencer
`default_nettype none
// Allocates and frees fixed-size chunks over up to SLABS slabs of CHUNKS_PER_SLAB
// chunks, one used bitmap per slab held in a memory with a registered read. One item
// is worked on at a time; a finished result waits in the output register while the
// next request beat is taken. An allocate reads the slabs in order, through ST_A_RD
// and ST_A_CHK for each slab scanned, and then steps through ST_A_MUL for the address
// multiply, ST_A_ADD for the add and range check with write-back, and ST_PUSH for the
// output. A free runs a bit-serial divider over IW = clog2(SLABS * CHUNKS_PER_SLAB)
// quotient bits (8 at the defaults) that turns the offset into a chunk index; a
// reciprocal multiply then splits the index into slab and bit. The bitmaps read as
// zero after reset through per-slab valid flags; there is no clearing pass. A zero
// chunk size answers every request with ok low.
module bitmap_chunk_allocator #(
    parameter int CHUNKS_PER_SLAB = 64,
    parameter int SLABS           = 4
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    bca_req_if.sink                       i_req,
    bca_rsp_if.source                     o_rsp,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [bca_pkg::APB_AW-1:0]     paddr,
    input  wire [bca_pkg::APB_DW-1:0]     pwdata,
    output logic [bca_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int AW   = bca_pkg::ADDR_W;
    localparam int CSW  = bca_pkg::CS_W;
    localparam int CH   = CHUNKS_PER_SLAB;
    localparam int SW   = (SLABS > 1) ? $clog2(SLABS) : 1;
    localparam int IW   = (SLABS * CH > 1) ? $clog2(SLABS * CH) : 1;
    localparam int BW   = (CH > 1) ? $clog2(CH) : 1;
    localparam int UW   = $clog2(SLABS + 1);
    localparam int UW1  = UW + 1;
    localparam int MW   = IW + 1;
    localparam int PW   = MW + CSW;
    localparam int SUMW = ((PW > AW) ? PW : AW) + 1;
    localparam int CNW  = $clog2(IW + 1);
    localparam int RSH  = IW + BW;
    localparam int RCW  = RSH + 1;
    localparam int RPW  = IW + RCW;

    localparam logic [UW1-1:0] SLABS_U = UW1'(SLABS);
    localparam logic [CH-1:0]  ONE_CH  = CH'(1);
    localparam logic [RCW-1:0] RECIP   = RCW'((2 ** RSH + CH - 1) / CH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_MUL,
        ST_A_ADD,
        ST_F_MUL,
        ST_F_CMP,
        ST_F_DIV1,
        ST_F_SLAB,
        ST_F_BIT,
        ST_F_RD,
        ST_F_WR,
        ST_PUSH
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_base;
    logic [CSW-1:0]      r_cs;
    logic [UW-1:0]       r_in_use;
    logic [SLABS-1:0]    r_vld;
    logic [CH-1:0]       r_mem [SLABS];
    logic [CH-1:0]       r_rd_data;
    logic                r_rd_vld;
    logic [SW-1:0]       r_slab;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_off;
    logic [MW-1:0]       r_idx;
    logic [BW-1:0]       r_bit;
    logic [CH-1:0]       r_map;
    logic [PW-1:0]       r_prod;
    logic [CSW-1:0]      r_rem;
    logic [IW-1:0]       r_dlo;
    logic [IW-1:0]       r_quo;
    logic [CSW-1:0]      r_dsr;
    logic [CNW-1:0]      r_cnt;
    logic [AW-1:0]       r_res_addr;
    logic                r_res_ok;
    logic                r_out_valid;
    logic [AW-1:0]       r_out_addr;
    logic                r_out_ok;

    logic [CH-1:0]       rd_eff;
    logic                fc_found;
    logic [BW-1:0]       fc_idx;
    logic                scan_more;
    logic [UW1-1:0]      slab_nx;
    logic [MW-1:0]       in_use_c;
    logic [MW-1:0]       mult_a;
    logic [PW-1:0]       prod;
    logic [SUMW-1:0]     sum;
    logic                ovf;
    logic [CSW:0]        dv_t;
    logic                dv_ge;
    logic [CSW-1:0]      n_rem;
    logic [IW-1:0]       n_quo;
    logic [RPW-1:0]      slab_prod;
    logic [IW-1:0]       slab_base;
    logic [CH-1:0]       bit_mask;
    logic                wr_en;
    logic [CH-1:0]       wr_data;
    logic                cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == bca_pkg::REG_CHUNK_SIZE) ? bca_pkg::APB_DW'(r_cs) : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_cs   <= bca_pkg::CHUNK_SIZE_RESET;
        end else if (cfg_wr) begin
            case (paddr)
                bca_pkg::REG_BASE_ADDRESS: r_base <= pwdata[AW-1:0];
                bca_pkg::REG_CHUNK_SIZE:   r_cs   <= pwdata[CSW-1:0];
                default: ;
            endcase
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_slab] <= wr_data;
        end
        r_rd_data <= r_mem[r_slab];
        r_rd_vld  <= r_vld[r_slab];
    end

    assign rd_eff = r_rd_vld ? r_rd_data : '0;

    // lowest clear bit
    always_comb begin
        fc_found = 1'b0;
        fc_idx   = '0;
        for (int i = CH - 1; i >= 0; i--) begin
            if (!rd_eff[i]) begin
                fc_found = 1'b1;
                fc_idx   = BW'(i);
            end
        end
    end

    assign slab_nx   = UW1'(r_slab) + UW1'(1);
    assign scan_more = (slab_nx < UW1'(r_in_use)) ||
                       ((slab_nx == UW1'(r_in_use)) && (UW1'(r_in_use) < SLABS_U));

    assign in_use_c = MW'(r_in_use) * MW'(CH);
    assign mult_a   = (r_state == ST_A_MUL) ? r_idx : in_use_c;
    assign prod     = PW'(mult_a) * PW'(r_cs);
    assign sum      = SUMW'(r_base) + SUMW'(r_prod);
    assign ovf      = |sum[SUMW-1:AW];

    // one restoring divide step
    assign dv_t  = {r_rem, r_dlo[IW-1]};
    assign dv_ge = dv_t >= {1'b0, r_dsr};
    assign n_rem = dv_ge ? CSW'(dv_t - {1'b0, r_dsr}) : dv_t[CSW-1:0];
    assign n_quo = IW'({r_quo, dv_ge});

    // chunk index to slab and bit
    assign slab_prod = RPW'(r_quo) * RPW'(RECIP);
    assign slab_base = IW'(r_slab) * IW'(CH);

    assign bit_mask = ONE_CH << r_bit;
    assign wr_en    = ((r_state == ST_A_ADD) && !ovf) || (r_state == ST_F_WR);
    assign wr_data  = (r_state == ST_A_ADD) ? (r_map | bit_mask) : (rd_eff & ~bit_mask);

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.chunk_address = r_out_addr;
    assign o_rsp.ok            = r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_use    <= UW'(1);
            r_vld       <= '0;
            r_slab      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != ST_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_addr     <= i_req.address;
                        r_slab     <= '0;
                        r_res_addr <= '0;
                        r_res_ok   <= 1'b0;
                        if (r_cs == '0) begin
                            r_state <= ST_PUSH;
                        end else if (i_req.op == bca_pkg::OP_ALLOC) begin
                            r_state <= ST_A_RD;
                        end else begin
                            r_state <= ST_F_MUL;
                        end
                    end
                end
                ST_A_RD: begin
                    r_state <= ST_A_CHK;
                end
                ST_A_CHK: begin
                    if (fc_found) begin
                        r_idx   <= MW'(r_slab) * MW'(CH) + MW'(fc_idx);
                        r_bit   <= fc_idx;
                        r_map   <= rd_eff;
                        r_state <= ST_A_MUL;
                    end else if (scan_more) begin
                        r_slab  <= slab_nx[SW-1:0];
                        r_state <= ST_A_RD;
                    end else begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_A_MUL: begin
                    r_prod  <= prod;
                    r_state <= ST_A_ADD;
                end
                ST_A_ADD: begin
                    if (!ovf) begin
                        r_res_addr    <= sum[AW-1:0];
                        r_res_ok      <= 1'b1;
                        r_vld[r_slab] <= 1'b1;
                        if (UW'(r_slab) == r_in_use) begin
                            r_in_use <= r_in_use + UW'(1);
                        end
                    end
                    r_state <= ST_PUSH;
                end
                ST_F_MUL: begin
                    r_prod <= prod;
                    r_off  <= r_addr - r_base;
                    if (r_addr < r_base) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_state <= ST_F_CMP;
                    end
                end
                ST_F_CMP: begin
                    if (SUMW'(r_off) >= SUMW'(r_prod)) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_rem   <= CSW'(r_off >> IW);
                        r_dlo   <= r_off[IW-1:0];
                        r_quo   <= '0;
                        r_dsr   <= r_cs;
                        r_cnt   <= CNW'(IW);
                        r_state <= ST_F_DIV1;
                    end
                end
                ST_F_DIV1: begin
                    r_rem <= n_rem;
                    r_dlo <= r_dlo << 1;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNW'(1);
                    if (r_cnt == CNW'(1)) begin
                        r_state <= ST_F_SLAB;
                    end
                end
                ST_F_SLAB: begin
                    r_slab  <= slab_prod[RSH +: SW];
                    r_state <= ST_F_BIT;
                end
                ST_F_BIT: begin
                    r_bit   <= BW'(r_quo - slab_base);
                    r_state <= ST_F_RD;
                end
                ST_F_RD: begin
                    r_state <= ST_F_WR;
                end
                ST_F_WR: begin
                    r_vld[r_slab] <= 1'b1;
                    r_res_ok      <= 1'b1;
                    r_state       <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_addr  <= r_res_addr;
                        r_out_ok    <= r_res_ok;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_in_use_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_use != '0) && (UW1'(r_in_use) <= SLABS_U))
        else $error("slab count out of range");

    a_in_use_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_in_use != $past(r_in_use))) |->
        (r_in_use == $past(r_in_use) + UW'(1)))
        else $error("slab count moved by more than one");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_DIV1) |-> (r_dsr != '0))
        else $error("divide by zero");

    a_write_then_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == ST_PUSH))
        else $error("bitmap write not followed by result");
`endif

endmodule
`default_nettype wire
